FILE: rtl/swst_pkg.sv
package swst_pkg;

   localparam int VALUE_W = 24;
   localparam int COUNT_W = 5;
   localparam int MODE_W  = 2;

   localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

   localparam logic CSR_SAMPLE_COUNT    = 1'b0;
   localparam logic CSR_PROCESSING_MODE = 1'b1;

   typedef enum logic [17:0] {
      ST_IDLE    = 18'b000000000000000001,
      ST_SUM_A   = 18'b000000000000000010,
      ST_SUM_B   = 18'b000000000000000100,
      ST_DM_GO   = 18'b000000000000001000,
      ST_DM_WAIT = 18'b000000000000010000,
      ST_SQ_A    = 18'b000000000000100000,
      ST_SQ_B    = 18'b000000000001000000,
      ST_SQ_L    = 18'b000000000010000000,
      ST_SQ_H    = 18'b000000000100000000,
      ST_DV_GO   = 18'b000000001000000000,
      ST_DV_WAIT = 18'b000000010000000000,
      ST_SQRT    = 18'b000000100000000000,
      ST_MI_A    = 18'b000001000000000000,
      ST_MI_B    = 18'b000010000000000000,
      ST_MJ_A    = 18'b000100000000000000,
      ST_MJ_B    = 18'b001000000000000000,
      ST_MED_FIN = 18'b010000000000000000,
      ST_OUT     = 18'b100000000000000000
   } state_type;

endpackage

FILE: rtl/swst_div.sv
module swst_div #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic             ge;

   always_comb begin
      shifted = {r_ff, q_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         r_in   = ge ? DEN_W'(shifted - {1'b0, d_ff}) : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: rtl/sample_window_statistics.sv
// Sample window statistics.
// req_ carries one nonzero sample per transaction; zero samples are dropped.
// When the configured number of samples has been collected, one transaction
// leaves on rsp_: the selected value (last sample, truncated mean or median)
// and the population standard deviation, both in the sample format.
// csr_ writes sample_count (index 0, also restarts the run) and
// processing_mode (index 1); the user must write only while the block is idle (not enforced).
// A sample that does not end a run is taken while the block is idle. A sample
// that ends a run of n starts a sequencer over the sample memory (one read per
// step): the sum, the squared deviations (24x12 multiplier, two passes per
// sample), two divisions by n on a shared bit-serial divider, a square root and,
// in median mode, rank counting of each sample against every sample.
// req_tready is low while the sequencer runs and while the result waits on a
// stalled receiver; the result holds until rsp_tready takes it.
// Reset clears the fill count and sets sample_count 1, processing_mode 0.
module sample_window_statistics
   import swst_pkg::*;
#(
   parameter int SAMPLE_CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [23:0] sample_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // [23:0] selected_value, [47:24] std_deviation
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [4:0]   csr_wdata
);

   localparam int NCW = $clog2(SAMPLE_CAPACITY + 1);
   localparam int AW  = (SAMPLE_CAPACITY > 1) ? $clog2(SAMPLE_CAPACITY) : 1;
   localparam int SW  = VALUE_W + NCW;
   localparam int QW  = 2 * VALUE_W + NCW;
   localparam int RW  = QW + (QW % 2);
   localparam int HW  = VALUE_W / 2;

   logic [VALUE_W-1:0] store [SAMPLE_CAPACITY];
   logic [VALUE_W-1:0] rd_ff;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [NCW-1:0]     fill_ff, fill_in;
   logic [NCW-1:0]     i_ff, i_in, j_ff, j_in;
   logic [NCW-1:0]     lt_ff, lt_in, le_ff, le_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [QW-1:0]      sq_ff, sq_in;
   logic [VALUE_W-1:0] mean_ff, mean_in, last_ff, last_in, d_ff, d_in;
   logic [VALUE_W-1:0] cand_ff, cand_in, mhi_ff, mhi_in, mlo_ff, mlo_in;
   logic [VALUE_W-1:0] sel_ff, sel_in, std_ff, std_in;
   logic [RW-1:0]      rv_ff, rv_in, root_ff, root_in, bit_ff, bit_in;

   logic [COUNT_W-1:0] cnt0;
   logic [NCW-1:0]     n, n_m1, wr_ptr, fill_nx, k_hi, k_lo, lt_nx, le_nx;
   logic [AW-1:0]      rd_addr;
   logic               accept, div_start, div_done;
   logic [QW-1:0]      div_num, div_quot;
   logic [HW+VALUE_W-1:0] prod;
   logic [RW-1:0]      trial;

   always_comb begin
      cnt0 = (count_ff == '0) ? COUNT_W'(1) : count_ff;
      if (32'(cnt0) > SAMPLE_CAPACITY) n = NCW'(SAMPLE_CAPACITY);
      else n = NCW'(cnt0);
      n_m1 = n - NCW'(1);
      k_hi = n >> 1;
      k_lo = k_hi - NCW'(1);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready && (req_tdata != '0);
   assign wr_ptr     = (fill_ff >= n) ? '0 : fill_ff;
   assign fill_nx    = wr_ptr + NCW'(1);
   assign rd_addr    = (state_ff == ST_MJ_A || state_ff == ST_MJ_B) ? j_ff[AW-1:0]
                                                                    : i_ff[AW-1:0];
   assign div_start  = (state_ff == ST_DM_GO) || (state_ff == ST_DV_GO);
   assign div_num    = (state_ff == ST_DM_GO) ? QW'(sum_ff) : sq_ff;
   assign prod       = d_ff * ((state_ff == ST_SQ_H) ? d_ff[VALUE_W-1:HW] : d_ff[HW-1:0]);
   assign trial      = root_ff + bit_ff;
   assign lt_nx      = lt_ff + NCW'(rd_ff < cand_ff);
   assign le_nx      = le_ff + NCW'(rd_ff <= cand_ff);

   swst_div #(.NUM_W(QW), .DEN_W(NCW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (n),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (accept) store[wr_ptr[AW-1:0]] <= req_tdata;
      rd_ff <= store[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      mean_in  = mean_ff;
      last_in  = last_ff;
      d_in     = d_ff;
      cand_in  = cand_ff;
      mhi_in   = mhi_ff;
      mlo_in   = mlo_ff;
      sel_in   = sel_ff;
      std_in   = std_ff;
      rv_in    = rv_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tdata;
               if (fill_nx >= n) begin
                  fill_in  = '0;
                  i_in     = '0;
                  sum_in   = '0;
                  state_in = ST_SUM_A;
               end else begin
                  fill_in = fill_nx;
               end
            end
         end
         ST_SUM_A: state_in = ST_SUM_B;
         ST_SUM_B: begin
            sum_in = sum_ff + SW'(rd_ff);
            i_in   = i_ff + NCW'(1);
            state_in = (i_ff == n_m1) ? ST_DM_GO : ST_SUM_A;
         end
         ST_DM_GO: state_in = ST_DM_WAIT;
         ST_DM_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot[VALUE_W-1:0];
               i_in     = '0;
               sq_in    = '0;
               state_in = ST_SQ_A;
            end
         end
         ST_SQ_A: state_in = ST_SQ_B;
         ST_SQ_B: begin
            d_in = (rd_ff >= mean_ff) ? rd_ff - mean_ff : mean_ff - rd_ff;
            state_in = ST_SQ_L;
         end
         ST_SQ_L: begin
            sq_in    = sq_ff + QW'(prod);
            state_in = ST_SQ_H;
         end
         ST_SQ_H: begin
            sq_in = sq_ff + (QW'(prod) << HW);
            i_in  = i_ff + NCW'(1);
            state_in = (i_ff == n_m1) ? ST_DV_GO : ST_SQ_A;
         end
         ST_DV_GO: state_in = ST_DV_WAIT;
         ST_DV_WAIT: begin
            if (div_done) begin
               rv_in    = RW'(div_quot);
               root_in  = '0;
               bit_in   = RW'(1) << (RW - 2);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rv_ff >= trial) begin
               rv_in   = rv_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               std_in = root_in[VALUE_W-1:0];
               case (mode_ff)
                  MODE_MEAN: begin
                     sel_in   = mean_ff;
                     state_in = ST_OUT;
                  end
                  MODE_MEDIAN: begin
                     i_in     = '0;
                     state_in = ST_MI_A;
                  end
                  default: begin
                     sel_in   = last_ff;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MI_A: state_in = ST_MI_B;
         ST_MI_B: begin
            cand_in  = rd_ff;
            j_in     = '0;
            lt_in    = '0;
            le_in    = '0;
            state_in = ST_MJ_A;
         end
         ST_MJ_A: state_in = ST_MJ_B;
         ST_MJ_B: begin
            lt_in = lt_nx;
            le_in = le_nx;
            j_in  = j_ff + NCW'(1);
            if (j_ff == n_m1) begin
               if (lt_nx <= k_hi && k_hi < le_nx) mhi_in = cand_ff;
               if (lt_nx <= k_lo && k_lo < le_nx) mlo_in = cand_ff;
               i_in     = i_ff + NCW'(1);
               state_in = (i_ff == n_m1) ? ST_MED_FIN : ST_MI_A;
            end else begin
               state_in = ST_MJ_A;
            end
         end
         ST_MED_FIN: begin
            if (n[0]) sel_in = mhi_ff;
            else sel_in = VALUE_W'(({1'b0, mhi_ff} + {1'b0, mlo_ff}) >> 1);
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_index == CSR_SAMPLE_COUNT) fill_in = '0;
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      lt_ff   <= lt_in;
      le_ff   <= le_in;
      sum_ff  <= sum_in;
      sq_ff   <= sq_in;
      mean_ff <= mean_in;
      last_ff <= last_in;
      d_ff    <= d_in;
      cand_ff <= cand_in;
      mhi_ff  <= mhi_in;
      mlo_ff  <= mlo_in;
      sel_ff  <= sel_in;
      std_ff  <= std_in;
      rv_ff   <= rv_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= COUNT_W'(1);
         mode_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_COUNT:    count_ff <= csr_wdata;
               CSR_PROCESSING_MODE: mode_ff  <= csr_wdata[MODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {std_ff, sel_ff};

endmodule

FILE: tb/testbench.sv
module testbench
   import swst_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int SETTLE_CYCLES = 1500;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [VALUE_W-1:0] std_deviation;
      logic [VALUE_W-1:0] selected_value;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // [23:0] sample_value
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [23:0] selected_value, [47:24] std_deviation
   logic csr_we = 1'b0;
   logic csr_index = CSR_SAMPLE_COUNT;
   logic [4:0] csr_wdata = '0;
   logic req_taken = 1'b0;

   logic [VALUE_W-1:0] sample_queue[$];
   stats_type stats_queue[$];
   longint cycle_count = 0;
   int mismatches = 0;
   int items_queued = 0;

   // predictor state
   logic [VALUE_W-1:0] win_store[CAPACITY];
   int win_fill = 0;
   logic [COUNT_W-1:0] win_count = 5'd1;
   logic [MODE_W-1:0] win_mode = '0;

   sample_window_statistics uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic int window_size();
      int n;
      n = int'(win_count);
      if (n == 0) n = 1;
      if (n > CAPACITY) n = CAPACITY;
      return n;
   endfunction

   // Stores one sample; pushes the window statistics when the run completes.
   function automatic void collect_sample(logic [VALUE_W-1:0] v);
      int n;
      logic [63:0] sum;
      logic [63:0] sq;
      logic [63:0] d;
      logic [VALUE_W-1:0] mean;
      logic [VALUE_W-1:0] sorted[CAPACITY];
      logic [VALUE_W-1:0] t;
      stats_type r;
      if (v == 0) return;
      n = window_size();
      if (win_fill >= n) win_fill = 0;
      win_store[win_fill] = v;
      win_fill++;
      if (win_fill < n) return;
      win_fill = 0;
      sum = 0;
      for (int i = 0; i < n; i++) sum += win_store[i];
      mean = VALUE_W'(sum / n);
      sq = 0;
      for (int i = 0; i < n; i++) begin
         d = (win_store[i] >= mean) ? win_store[i] - mean : mean - win_store[i];
         sq += d * d;
      end
      r.std_deviation = VALUE_W'(isqrt(sq / n));
      case (win_mode)
         MODE_MEAN: r.selected_value = mean;
         MODE_MEDIAN: begin
            for (int i = 0; i < n; i++) sorted[i] = win_store[i];
            for (int i = 1; i < n; i++)
               for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
                  t = sorted[j];
                  sorted[j] = sorted[j-1];
                  sorted[j-1] = t;
               end
            if (n % 2 == 1) r.selected_value = sorted[n/2];
            else r.selected_value =
               VALUE_W'(({1'b0, sorted[n/2]} + {1'b0, sorted[n/2-1]}) >> 1);
         end
         default: r.selected_value = v;
      endcase
      stats_queue.push_back(r);
   endfunction

   function automatic logic [VALUE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return '0;
      if (pick < 40) return VALUE_W'($urandom());
      if (pick < 65) return VALUE_W'($urandom_range(1, 255));
      if (pick < 80) return VALUE_W'(32'hFFFFFF - $urandom_range(0, 4095));
      return VALUE_W'(32'h400000 + $urandom_range(0, 8191));
   endfunction

   // driver
   always @(negedge clock) begin
      logic idle;
      logic held;
      idle = (cycle_count < 3000 || cycle_count > 9000) && ($urandom_range(0, 99) < 25);
      rsp_tready <= (cycle_count >= 3000 && cycle_count <= 9000) ||
                    ($urandom_range(0, 99) >= 25);
      held = req_tvalid && !req_taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!held) begin
         if (!idle && sample_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= sample_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stats_type got;
      stats_type want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sample_window_statistics: mismatch");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) collect_sample(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (stats_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", got);
         end else begin
            want = stats_queue.pop_front();
            if (got.selected_value !== want.selected_value ||
                got.std_deviation !== want.std_deviation) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sel exp %h got %h, std exp %h got %h",
                           want.selected_value, got.selected_value,
                           want.std_deviation, got.std_deviation);
            end
         end
      end
   end

   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_tvalid || stats_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [4:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_SAMPLE_COUNT) begin
         win_count = value;
         win_fill = 0;
      end else begin
         win_mode = value[MODE_W-1:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic enqueue(logic [VALUE_W-1:0] v);
      sample_queue.push_back(v);
      items_queued++;
   endtask

   initial begin
      int n;
      int extra;
      int total;
      logic [1:0] m;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-sample runs, extremes and ignored zero
      enqueue(24'hFFFFFF);
      enqueue(24'h000000);
      enqueue(24'h000001);
      wait_idle();
      write_csr(CSR_SAMPLE_COUNT, 5'd0);
      write_csr(CSR_PROCESSING_MODE, 5'd3);
      enqueue(24'hABCDEF);
      wait_idle();
      // even median with wide spread
      write_csr(CSR_SAMPLE_COUNT, 5'd4);
      write_csr(CSR_PROCESSING_MODE, 5'(MODE_MEDIAN));
      enqueue(24'hFFFFFF);
      enqueue(24'h000001);
      enqueue(24'hFFFFFE);
      enqueue(24'h000003);
      wait_idle();
      // odd median
      write_csr(CSR_SAMPLE_COUNT, 5'd3);
      enqueue(24'h000010);
      enqueue(24'h000000);
      enqueue(24'h800000);
      enqueue(24'h000020);
      wait_idle();
      // run restart on count write
      write_csr(CSR_SAMPLE_COUNT, 5'd2);
      enqueue(24'h123456);
      wait_idle();
      write_csr(CSR_PROCESSING_MODE, 5'(MODE_MEAN));
      write_csr(CSR_SAMPLE_COUNT, 5'd2);
      enqueue(24'hFFFFFF);
      enqueue(24'hFFFFFF);
      wait_idle();
      // count above capacity, full window alternating maxima and ones
      write_csr(CSR_SAMPLE_COUNT, 5'd31);
      for (int i = 0; i < 16; i++) enqueue(i % 2 ? 24'hFFFFFF : 24'h000001);
      wait_idle();

      while (items_queued < 520) begin
         case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(16, 31);
            2, 3: n = $urandom_range(7, 15);
            default: n = $urandom_range(1, 6);
         endcase
         m = 2'($urandom_range(0, 3));
         write_csr(CSR_PROCESSING_MODE, 5'(m));
         write_csr(CSR_SAMPLE_COUNT, 5'(n));
         if (n > CAPACITY) n = CAPACITY;
         if (n == 0) n = 1;
         extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : 0;
         total = n * $urandom_range(1, 3) + extra;
         for (int i = 0; i < total; i++)
            enqueue(random_sample());
         wait_idle();
      end

      if (mismatches == 0 && stats_queue.size() == 0) begin
         $display("sample_window_statistics: match");
      end else begin
         $display("sample_window_statistics: mismatch");
      end
      $finish;
   end

endmodule
